// ===== design/rsdr_pkg.sv =====
// Shared types and constants for the RRIP replacement core.
package rsdr_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int SET_W       = 11;
  localparam int NUM_WAYS    = 16;
  localparam int WAY_W       = 4;
  localparam int SIG_BITS    = 6;
  localparam int SIG_ENTRIES = 64;
  localparam int ADDR_BITS   = 48;
  localparam int MASK_W      = 16;
  localparam int PERIOD_W    = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int SWEEP_W     = SET_W + 1;

  localparam logic [1:0] CNT_MAX  = 2'd3;
  localparam logic [1:0] RRPV_MAX = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ON    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_MRU    = 2'd2;

  localparam logic [PERIOD_W-1:0] DECAY_PERIOD_RST = 20'd100000;

  typedef struct packed {
    logic                  action;
    logic [SET_W-1:0]      set_idx;
    logic [WAY_W-1:0]      way_idx;
    logic [ADDR_BITS-1:0]  addr;
    logic [SIG_BITS-1:0]   sig;
    logic                  hit;
    logic [MASK_W-1:0]     mask;
  } item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]                prev;
    logic [1:0]                          score;
    logic [NUM_WAYS-1:0][SIG_BITS-1:0]   sig;
    logic [NUM_WAYS-1:0][1:0]            dead;
    logic [NUM_WAYS-1:0][1:0]            rrpv;
  } row_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             bypassed;
    logic             streaming_set;
  } result_t;

endpackage

// ===== design/rsdr_front.sv =====
// Request intake: field decode and a two-entry queue toward the back end.
module rsdr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_action_i,
  input  logic [127:0]     in_data_i,
  output logic             head_valid_o,
  output rsdr_pkg::item_t  head_o,
  input  logic             pop_i
);

  rsdr_pkg::item_t q_q [2];
  rsdr_pkg::item_t item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  always_comb begin
    item.action  = in_action_i;
    item.set_idx = in_data_i[10:0];
    item.way_idx = in_data_i[14:11];
    item.addr    = in_data_i[62:15];
    item.sig     = in_data_i[63+2+rsdr_pkg::SIG_BITS-1:63+2];
    item.hit     = in_data_i[111];
    item.mask    = in_data_i[127:112];
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

// ===== design/rsdr_back.sv =====
// Policy engine: set row and reuse table memories, victim search, update and sweeps.
module rsdr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  rsdr_pkg::item_t                   head_i,
  output logic                              pop_o,
  input  logic [rsdr_pkg::PERIOD_W-1:0]     decay_period_i,
  input  logic [1:0]                        stream_on_i,
  input  logic [1:0]                        reuse_mru_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rsdr_pkg::result_t                 out_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ROW  = 3'd2;
  localparam logic [2:0] ST_R1   = 3'd3;
  localparam logic [2:0] ST_R2   = 3'd4;
  localparam logic [2:0] ST_R3   = 3'd5;
  localparam logic [2:0] ST_DEC  = 3'd6;

  localparam logic [rsdr_pkg::SWEEP_W-1:0] SWEEP_LAST =
    rsdr_pkg::SWEEP_W'(rsdr_pkg::NUM_SETS - 1);
  localparam logic [rsdr_pkg::SWEEP_W-1:0] SWEEP_END =
    rsdr_pkg::SWEEP_W'(rsdr_pkg::NUM_SETS);
  localparam logic [rsdr_pkg::SWEEP_W-1:0] SIG_END =
    rsdr_pkg::SWEEP_W'(rsdr_pkg::SIG_ENTRIES);

  rsdr_pkg::row_t row_mem [rsdr_pkg::NUM_SETS];
  logic [1:0]     reuse_mem [rsdr_pkg::SIG_ENTRIES];

  logic [2:0] state_q, state_d;
  rsdr_pkg::item_t it_q;
  rsdr_pkg::row_t  row_rd_q;
  logic [1:0]      reuse_rd_q;

  logic                              row_re, row_we;
  logic [rsdr_pkg::SET_W-1:0]        row_raddr, row_waddr;
  rsdr_pkg::row_t                    row_wdata;
  logic                              reuse_re, reuse_we;
  logic [rsdr_pkg::SIG_BITS-1:0]     reuse_raddr, reuse_waddr;
  logic [1:0]                        reuse_wdata;

  logic [rsdr_pkg::SWEEP_W-1:0] sweep_q, sweep_d;
  logic [rsdr_pkg::SWEEP_W-1:0] widx_q, widx_d;
  logic                         wv_q, wv_d;
  logic [rsdr_pkg::PERIOD_W-1:0] dcnt_q, dcnt_d;
  logic                         pend_q, pend_d;
  logic [1:0]                   score_q, score_d;
  logic                         strm_q, strm_d;
  logic [rsdr_pkg::SIG_BITS-1:0] raddr_q, raddr_d;

  logic              out_valid_q, out_valid_d;
  rsdr_pkg::result_t out_q, out_d;
  logic              out_free;

  // victim search
  logic [rsdr_pkg::WAY_W-1:0] inv_way, dead_way, top_way, vic_way;
  logic inv_hit, dead_hit, top_hit, age;
  logic [1:0] top;
  rsdr_pkg::row_t aged_row;

  // update
  logic [rsdr_pkg::ADDR_BITS-1:0] diff;
  logic [1:0] score_n, dead_old, dead_n, reuse_sig;
  logic [rsdr_pkg::SIG_BITS-1:0] old_sig;
  logic [rsdr_pkg::PERIOD_W-1:0] period, cnt_n;
  logic bypass, mru;
  rsdr_pkg::row_t upd_row, dec_row, clr_row;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    inv_hit = 1'b0; dead_hit = 1'b0; top_hit = 1'b0;
    inv_way = '0; dead_way = '0; top_way = '0;
    top = 2'd0;
    for (int i = 0; i < rsdr_pkg::NUM_WAYS; i++) begin
      if (row_rd_q.rrpv[i] > top) top = row_rd_q.rrpv[i];
    end
    for (int i = rsdr_pkg::NUM_WAYS - 1; i >= 0; i--) begin
      if (!it_q.mask[i]) begin
        inv_hit = 1'b1; inv_way = rsdr_pkg::WAY_W'(i);
      end
      if (row_rd_q.dead[i] == rsdr_pkg::CNT_MAX) begin
        dead_hit = 1'b1; dead_way = rsdr_pkg::WAY_W'(i);
      end
      if (row_rd_q.rrpv[i] == top) begin
        top_hit = 1'b1; top_way = rsdr_pkg::WAY_W'(i);
      end
    end
    age = !inv_hit && !dead_hit && (top != rsdr_pkg::RRPV_MAX);
    vic_way = inv_hit ? inv_way : (dead_hit ? dead_way : (top_hit ? top_way : '0));
    aged_row = row_rd_q;
    for (int i = 0; i < rsdr_pkg::NUM_WAYS; i++) begin
      aged_row.rrpv[i] = row_rd_q.rrpv[i] + (rsdr_pkg::RRPV_MAX - top);
    end
  end

  always_comb begin
    diff = (it_q.addr > row_rd_q.prev) ? it_q.addr - row_rd_q.prev
                                       : row_rd_q.prev - it_q.addr;
    if (row_rd_q.prev == '0) begin
      score_n = 2'd0;
    end else if (diff == rsdr_pkg::ADDR_BITS'(64) || diff == rsdr_pkg::ADDR_BITS'(128)) begin
      score_n = (row_rd_q.score == rsdr_pkg::CNT_MAX) ? row_rd_q.score : row_rd_q.score + 2'd1;
    end else begin
      score_n = (row_rd_q.score == 2'd0) ? 2'd0 : row_rd_q.score - 2'd1;
    end
    old_sig = row_rd_q.sig[it_q.way_idx];
    period  = (decay_period_i == '0) ? rsdr_pkg::PERIOD_W'(1) : decay_period_i;
    cnt_n   = dcnt_q + rsdr_pkg::PERIOD_W'(1);

    dead_old  = row_rd_q.dead[it_q.way_idx];
    dead_n    = it_q.hit ? 2'd0
              : ((dead_old == rsdr_pkg::CNT_MAX) ? dead_old : dead_old + 2'd1);
    reuse_sig = reuse_rd_q;
    bypass    = (dead_n == rsdr_pkg::CNT_MAX);
    mru       = !bypass && !strm_q && (reuse_sig >= reuse_mru_i);
    upd_row   = row_rd_q;
    upd_row.prev = it_q.addr;
    upd_row.score = score_q;
    upd_row.sig[it_q.way_idx]  = it_q.sig;
    upd_row.dead[it_q.way_idx] = dead_n;
    upd_row.rrpv[it_q.way_idx] = mru ? 2'd0 : rsdr_pkg::RRPV_MAX;

    dec_row = row_rd_q;
    for (int i = 0; i < rsdr_pkg::NUM_WAYS; i++) begin
      dec_row.dead[i] = (row_rd_q.dead[i] == 2'd0) ? 2'd0 : row_rd_q.dead[i] - 2'd1;
    end

    clr_row = '0;
    clr_row.rrpv = '1;
  end

  always_comb begin
    state_d = state_q;
    pop_o = 1'b0;
    row_re = 1'b0; row_raddr = head_i.set_idx;
    row_we = 1'b0; row_waddr = it_q.set_idx; row_wdata = upd_row;
    reuse_re = 1'b0; reuse_raddr = it_q.sig;
    reuse_we = 1'b0; reuse_waddr = raddr_q; reuse_wdata = 2'd0;
    sweep_d = sweep_q; widx_d = widx_q; wv_d = wv_q;
    dcnt_d = dcnt_q; pend_d = pend_q; score_d = score_q; strm_d = strm_q;
    raddr_d = raddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    case (state_q)
      ST_CLR: begin
        row_we = 1'b1;
        row_waddr = sweep_q[rsdr_pkg::SET_W-1:0];
        row_wdata = clr_row;
        reuse_we = (sweep_q < SIG_END);
        reuse_waddr = sweep_q[rsdr_pkg::SIG_BITS-1:0];
        reuse_wdata = 2'd1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          row_re = 1'b1;
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (!it_q.action) begin
          if (out_free) begin
            row_we = age;
            row_wdata = aged_row;
            out_valid_d = 1'b1;
            out_d.victim_way = vic_way;
            out_d.bypassed = 1'b0;
            out_d.streaming_set = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          pend_d = (cnt_n >= period);
          dcnt_d = (cnt_n >= period) ? '0 : cnt_n;
          score_d = score_n;
          strm_d = (score_n >= stream_on_i);
          raddr_d = it_q.hit ? it_q.sig : old_sig;
          reuse_re = 1'b1;
          reuse_raddr = it_q.hit ? it_q.sig : old_sig;
          state_d = ST_R1;
        end
      end
      ST_R1: begin
        reuse_we = 1'b1;
        reuse_wdata = it_q.hit
          ? ((reuse_rd_q == rsdr_pkg::CNT_MAX) ? reuse_rd_q : reuse_rd_q + 2'd1)
          : ((reuse_rd_q == 2'd0) ? 2'd0 : reuse_rd_q - 2'd1);
        state_d = ST_R2;
      end
      ST_R2: begin
        reuse_re = 1'b1;
        state_d = ST_R3;
      end
      ST_R3: begin
        if (out_free) begin
          row_we = 1'b1;
          out_valid_d = 1'b1;
          out_d.victim_way = it_q.way_idx;
          out_d.bypassed = bypass;
          out_d.streaming_set = strm_q;
          if (pend_q && !bypass) begin
            sweep_d = '0;
            wv_d = 1'b0;
            state_d = ST_DEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DEC: begin
        row_re = (sweep_q < SWEEP_END);
        row_raddr = sweep_q[rsdr_pkg::SET_W-1:0];
        reuse_re = (sweep_q < SIG_END);
        reuse_raddr = sweep_q[rsdr_pkg::SIG_BITS-1:0];
        if (sweep_q < SWEEP_END) sweep_d = sweep_q + 1'b1;
        wv_d = (sweep_q < SWEEP_END);
        widx_d = sweep_q;
        row_we = wv_q;
        row_waddr = widx_q[rsdr_pkg::SET_W-1:0];
        row_wdata = dec_row;
        reuse_we = wv_q && (widx_q < SIG_END);
        reuse_waddr = widx_q[rsdr_pkg::SIG_BITS-1:0];
        reuse_wdata = (reuse_rd_q == 2'd0) ? 2'd0 : reuse_rd_q - 2'd1;
        if (wv_q && widx_q == SWEEP_LAST) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (row_re) row_rd_q <= row_mem[row_raddr];
    if (reuse_we) reuse_mem[reuse_waddr] <= reuse_wdata;
    if (reuse_re) reuse_rd_q <= reuse_mem[reuse_raddr];
    if (pop_o) it_q <= head_i;
    out_q   <= out_d;
    score_q <= score_d;
    strm_q  <= strm_d;
    raddr_q <= raddr_d;
    widx_q  <= widx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      sweep_q     <= '0;
      wv_q        <= 1'b0;
      dcnt_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      wv_q        <= wv_d;
      dcnt_q      <= dcnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/rrip_ship_dead_stream_replacement_core.sv =====
// Top level of the RRIP replacement core with signature reuse, dead and stride tracking.
// Victim query: the set row is read from the queue head, then the result is registered.
// Update: row read, then read, write and second read of reuse table, then row write.
// An update that ends a decay period, unless bypassed, adds a sweep over the set rows.
// Reset is asynchronous; then a clearing pass over all 2048 set rows runs before the
// first request is processed (requests queue meanwhile, configuration writes are taken).
module rrip_ship_dead_stream_replacement_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // set_index, way_index, phys_addr, pc_addr, was_hit, valid_mask
  input  logic [127:0]                       s_axis_tdata_i,
  // action
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // victim_way, bypassed, streaming_set, zero pad
  output logic [7:0]                         m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [rsdr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rsdr_pkg::PERIOD_W-1:0]      cfg_data_i
);

  logic [rsdr_pkg::PERIOD_W-1:0] decay_period_q;
  logic [1:0] stream_on_q, reuse_mru_q;
  logic head_valid, pop;
  rsdr_pkg::item_t head;
  rsdr_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_period_q <= rsdr_pkg::DECAY_PERIOD_RST;
      stream_on_q    <= 2'd2;
      reuse_mru_q    <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsdr_pkg::CFG_DECAY_PERIOD: decay_period_q <= cfg_data_i;
        rsdr_pkg::CFG_STREAM_ON:    stream_on_q <= cfg_data_i[1:0];
        rsdr_pkg::CFG_REUSE_MRU:    reuse_mru_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  rsdr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_action_i  (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  rsdr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .decay_period_i (decay_period_q),
    .stream_on_i    (stream_on_q),
    .reuse_mru_i    (reuse_mru_q),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_o          (res)
  );

  assign m_axis_tdata_o = {2'b00, res.streaming_set, res.bypassed, res.victim_way};

endmodule
